// File: hdl/fq428_pkg.sv
// Shared types and constants for the float32 / Q4.28 converter.
// Holds the transaction structs, action codes and format constants.
// No dependencies.
package fq428_pkg;

    // Action codes carried by the input transaction.
    localparam logic ACTION_F2X = 1'b0;  // single precision bits to Q4.28
    localparam logic ACTION_X2F = 1'b1;  // Q4.28 to single precision bits

    // Single-precision layout.
    localparam int MANT_BITS = 23;
    localparam int EXP_BITS  = 8;
    localparam int EXP_BIAS  = 127;
    localparam logic [EXP_BITS-1:0] EXP_SPECIAL = 8'hFF;

    // Q4.28 layout.
    localparam int FIX_FRAC_BITS = 28;
    localparam int FIX_INT_BITS  = 4;

    // Exponent at and above which a float leaves the Q4.28 range.
    localparam logic [EXP_BITS-1:0] SAT_EXP = EXP_BITS'(EXP_BIAS + FIX_INT_BITS - 1);
    // Exponent at which the mantissa sits unshifted in the Q4.28 word.
    localparam logic [EXP_BITS-1:0] ALIGN_EXP =
        EXP_BITS'(EXP_BIAS - (FIX_FRAC_BITS - MANT_BITS));

    // Saturation words.
    localparam logic [31:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FIX_MIN = 32'h8000_0000;

    // Input transaction.
    typedef struct packed {
        logic        action;
        logic [31:0] operand;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
    } out_t;

endpackage

// File: hdl/fq428_f2x.sv
// Single-precision bit pattern to signed Q4.28, truncating toward zero.
// Purely combinational; depends on fq428_pkg.
module fq428_f2x (
    input  logic [31:0]     operand,
    output fq428_pkg::out_t res
);
    import fq428_pkg::*;

    logic                sign;
    logic [EXP_BITS-1:0] expo;
    logic [31:0]         mant;
    logic [EXP_BITS-1:0] lsh;
    logic [EXP_BITS-1:0] rsh;
    logic [31:0]         mag;

    // Split the float into its fields; the mantissa gets its implicit one.
    assign sign = operand[31];
    assign expo = operand[30:23];
    assign mant = {8'b0, 1'b1, operand[MANT_BITS-1:0]};
    assign lsh  = expo - ALIGN_EXP;
    assign rsh  = ALIGN_EXP - expo;

    // Align the mantissa to the Q4.28 binary point.
    always_comb begin
        if (expo >= ALIGN_EXP) begin
            mag = mant << lsh[2:0];
        end else if (rsh >= 8'd32) begin
            mag = '0;
        end else begin
            mag = mant >> rsh[4:0];
        end
    end

    // Handle zero, denormals and out-of-range values, then apply the sign.
    always_comb begin
        res.saturated = 1'b0;
        if (expo == '0) begin
            res.result = '0;
        end else if (expo == EXP_SPECIAL || expo >= SAT_EXP) begin
            res.saturated = 1'b1;
            res.result    = sign ? FIX_MIN : FIX_MAX;
        end else begin
            res.result = sign ? (32'd0 - mag) : mag;
        end
    end

endmodule

// File: hdl/fq428_x2f.sv
// Signed Q4.28 to single-precision bit pattern, truncating the mantissa.
// Purely combinational; depends on fq428_pkg.
module fq428_x2f (
    input  logic [31:0]     operand,
    output fq428_pkg::out_t res
);
    import fq428_pkg::*;

    logic                neg;
    logic [31:0]         absv;
    logic [4:0]          lz;
    logic [31:0]         norm;
    logic [EXP_BITS-1:0] expo;

    // Magnitude of the two's complement word; the most negative value maps to itself.
    assign neg  = operand[31];
    assign absv = neg ? (32'd0 - operand) : operand;

    // Leading-zero count as a priority encoder; the highest set bit wins.
    always_comb begin
        lz = 5'd31;
        for (int i = 0; i < 32; i++) begin
            if (absv[i]) begin
                lz = 5'(31 - i);
            end
        end
    end

    // Normalize so the leading one lands in the top bit, then build the exponent.
    assign norm = absv << lz;
    assign expo = SAT_EXP - EXP_BITS'(lz);

    // Assemble the float; a zero word gives positive zero.
    always_comb begin
        res.saturated = 1'b0;
        if (operand == '0) begin
            res.result = '0;
        end else begin
            res.result = {neg, expo, norm[30:31-MANT_BITS]};
        end
    end

endmodule

// File: hdl/float32_q4_28_converter.sv
// Path: an accepted input is held in the input register, then moves to the result register
// when the result side can take it.
// Throughput: one transaction per cycle while m_ready holds; each direction has its own
// datapath between the input register and the result register, selected by the action code.
// A stalled result holds in the result register; the input register takes one more
// transaction, then s_ready drops until the result side drains.
// Reset: synchronous, active low on aresetn; clears both valid flags, payloads are not reset.
// Depends on fq428_pkg, fq428_f2x and fq428_x2f.
module float32_q4_28_converter (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fq428_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fq428_pkg::out_t  m_data
);
    import fq428_pkg::*;

    logic in_valid_reg, in_valid_next;
    in_t  in_data_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;
    out_t f2x_res;
    out_t x2f_res;
    out_t conv_res;
    logic out_adv;

    // Pipeline advance: the result register moves when empty or drained.
    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;

    // Valid flags for the two register stages.
    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Conversion datapath, one per direction.
    fq428_f2x u_f2x (
        .operand (in_data_reg.operand),
        .res     (f2x_res)
    );

    fq428_x2f u_x2f (
        .operand (in_data_reg.operand),
        .res     (x2f_res)
    );

    // Pick the direction the transaction asked for.
    always_comb begin
        if (in_data_reg.action == ACTION_X2F) begin
            conv_res = x2f_res;
        end else begin
            conv_res = f2x_res;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_data_reg <= conv_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    // A saturated result is always one of the two clamp words.
    a_sat_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.saturated) |->
            (out_data_reg.result == FIX_MAX || out_data_reg.result == FIX_MIN))
        else $error("saturated result is not a clamp word");

    // An accepted transaction lands in the input register.
    a_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted transaction lost at input register");

    // A staged transaction moves on whenever the result side can take it.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv) |=> out_valid_reg)
        else $error("staged transaction lost at result register");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("result valid after reset");
`endif

endmodule
